FILE: src/lcdnw_pkg.sv
// Package with the shared types, codes and constants of the character LCD nibble writer.
`timescale 1ns / 1ps

package lcdnw_pkg;

   typedef enum logic [1:0] {
      MODE_COMMAND  = 2'd0,
      MODE_DATA     = 2'd1,
      MODE_INIT     = 2'd2,
      MODE_POSITION = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_NUM_LINES     = 3'd0,
      CSR_TALL_FONT     = 3'd1,
      CSR_DISPLAY_FLAGS = 3'd2,
      CSR_ENTRY_FLAGS   = 3'd3,
      CSR_CLOCKS_PER_US = 3'd4
   } csr_index_type;

   typedef enum logic {
      STEP_WAIT   = 1'b0,
      STEP_NIBBLE = 1'b1
   } step_kind_type;

   typedef enum logic {
      FRONT_IDLE = 1'b0,
      FRONT_RUN  = 1'b1
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE = 2'd0,
      BACK_EMIT = 2'd1,
      BACK_HOLD = 2'd2
   } back_state_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  value;
      logic [6:0]  column;
      logic [1:0]  row;
   } req_type;

   typedef struct packed {
      logic [3:0]  data_nibble;
      logic        register_select;
      logic        enable;
      logic [15:0] hold_us;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  num_lines;
      logic        tall_font;
      logic [2:0]  display_flags;
      logic [1:0]  entry_flags;
      logic [7:0]  clocks_per_us;
   } cfg_type;

   typedef struct packed {
      step_kind_type kind;
      logic [3:0]    nibble;
      logic          rs;
      logic [15:0]   extra_us;
      logic          last;
   } step_type;

   localparam logic [7:0]  FS_BASE         = 8'h20;
   localparam logic [7:0]  FS_TWO_LINE     = 8'h08;
   localparam logic [7:0]  FS_TALL_FONT    = 8'h04;
   localparam logic [7:0]  DISPLAY_BASE    = 8'h08;
   localparam logic [7:0]  ENTRY_BASE      = 8'h04;
   localparam logic [7:0]  CMD_CLEAR       = 8'h01;
   localparam logic [7:0]  CMD_SET_ADDRESS = 8'h80;
   localparam logic [3:0]  WAKE_NIBBLE     = 4'h3;
   localparam logic [3:0]  FOUR_BIT_NIBBLE = 4'h2;
   localparam logic [15:0] POWER_UP_US     = 16'd50000;
   localparam logic [15:0] WAKE_LONG_US    = 16'd4500;
   localparam logic [15:0] WAKE_SHORT_US   = 16'd150;
   localparam logic [15:0] LONG_CMD_US     = 16'd2000;
   localparam logic [15:0] SETTLE_US       = 16'd100;
   localparam logic [15:0] STROBE_US       = 16'd1;
   localparam logic [3:0]  INIT_LAST_STEP  = 4'd12;
   localparam logic [3:0]  BYTE_LAST_STEP  = 4'd1;

   localparam logic [2:0]  NUM_LINES_RESET     = 3'd1;
   localparam logic        TALL_FONT_RESET     = 1'b0;
   localparam logic [2:0]  DISPLAY_FLAGS_RESET = 3'd4;
   localparam logic [1:0]  ENTRY_FLAGS_RESET   = 2'd2;
   localparam logic [7:0]  CLOCKS_PER_US_RESET = 8'd16;

   function automatic logic [6:0] row_base(input logic [1:0] row);
      logic [6:0] base;
      case (row)
         2'd0:    base = 7'h00;
         2'd1:    base = 7'h40;
         2'd2:    base = 7'h14;
         2'd3:    base = 7'h54;
         default: base = 7'h00;
      endcase
      return base;
   endfunction

endpackage

FILE: src/lcdnw_fifo.sv
// Small register queue that carries nibble steps from the front part to the back part.
`timescale 1ns / 1ps

module lcdnw_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lcdnw_pkg::step_type push_data,
   output logic                full,
   input  logic                pop,
   output lcdnw_pkg::step_type pop_data,
   output logic                empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lcdnw_pkg::step_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/lcdnw_front.sv
// Front part: accepts requests, classifies them and breaks them into nibble steps.
`timescale 1ns / 1ps

module lcdnw_front (
   input  logic                clock,
   input  logic                reset,
   input  lcdnw_pkg::cfg_type  cfg,
   input  logic                req_push,
   input  lcdnw_pkg::req_type  req_data,
   output logic                req_full,
   output logic                step_push,
   output lcdnw_pkg::step_type step,
   input  logic                step_full
);

   lcdnw_pkg::front_state_type state_ff, state_in;
   lcdnw_pkg::mode_type        mode_ff, mode_in;
   logic [7:0]                 byte_ff, byte_in;
   logic                       rs_ff, rs_in;
   logic [3:0]                 idx_ff, idx_in;

   logic       accept;
   logic [2:0] lines;
   logic [1:0] row_clamped;
   logic [6:0] address;
   logic [7:0] fs_byte;
   logic [7:0] cur_byte;
   logic       is_byte;
   logic       lo_half;
   logic [3:0] last_idx;

   assign accept = req_push && !req_full;

   always_comb begin
      lines = (cfg.num_lines == 3'd0) ? 3'd1 : cfg.num_lines;
      row_clamped = req_data.row;
      if ({1'b0, req_data.row} >= lines) begin
         row_clamped = 2'(lines - 3'd1);
      end
      address = req_data.column + lcdnw_pkg::row_base(row_clamped);
   end

   always_comb begin
      fs_byte = lcdnw_pkg::FS_BASE;
      if (cfg.num_lines > 3'd1) begin
         fs_byte = fs_byte | lcdnw_pkg::FS_TWO_LINE;
      end
      if (cfg.tall_font && cfg.num_lines == 3'd1) begin
         fs_byte = fs_byte | lcdnw_pkg::FS_TALL_FONT;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcdnw_pkg::FRONT_IDLE: begin
            if (accept) begin
               state_in = lcdnw_pkg::FRONT_RUN;
            end
         end
         lcdnw_pkg::FRONT_RUN: begin
            if (!step_full && step.last) begin
               state_in = lcdnw_pkg::FRONT_IDLE;
            end
         end
         default: state_in = lcdnw_pkg::FRONT_IDLE;
      endcase
   end

   always_comb begin
      req_full  = 1'b1;
      step_push = 1'b0;
      case (state_ff)
         lcdnw_pkg::FRONT_IDLE: req_full = 1'b0;
         lcdnw_pkg::FRONT_RUN:  step_push = 1'b1;
         default: begin
            req_full  = 1'b1;
            step_push = 1'b0;
         end
      endcase
   end

   always_comb begin
      step          = '0;
      step.kind     = lcdnw_pkg::STEP_NIBBLE;
      step.rs       = rs_ff;
      cur_byte      = byte_ff;
      is_byte       = 1'b1;
      lo_half       = idx_ff[0];
      last_idx      = lcdnw_pkg::BYTE_LAST_STEP;
      if (mode_ff == lcdnw_pkg::MODE_INIT) begin
         last_idx = lcdnw_pkg::INIT_LAST_STEP;
         lo_half  = !idx_ff[0];
         case (idx_ff)
            4'd0: begin
               is_byte  = 1'b0;
               step.kind = lcdnw_pkg::STEP_WAIT;
            end
            4'd1, 4'd2: begin
               is_byte       = 1'b0;
               step.nibble   = lcdnw_pkg::WAKE_NIBBLE;
               step.extra_us = lcdnw_pkg::WAKE_LONG_US;
            end
            4'd3: begin
               is_byte       = 1'b0;
               step.nibble   = lcdnw_pkg::WAKE_NIBBLE;
               step.extra_us = lcdnw_pkg::WAKE_SHORT_US;
            end
            4'd4: begin
               is_byte     = 1'b0;
               step.nibble = lcdnw_pkg::FOUR_BIT_NIBBLE;
            end
            4'd5, 4'd6: cur_byte = fs_byte;
            4'd7, 4'd8: cur_byte = lcdnw_pkg::DISPLAY_BASE | {5'd0, cfg.display_flags};
            4'd9, 4'd10: cur_byte = lcdnw_pkg::CMD_CLEAR;
            default: cur_byte = lcdnw_pkg::ENTRY_BASE | {6'd0, cfg.entry_flags};
         endcase
      end
      if (is_byte) begin
         step.nibble = lo_half ? cur_byte[3:0] : cur_byte[7:4];
         if (lo_half && !step.rs && cur_byte >= 8'd1 && cur_byte <= 8'd3) begin
            step.extra_us = lcdnw_pkg::LONG_CMD_US;
         end
      end
      step.last = (idx_ff == last_idx);
   end

   always_comb begin
      mode_in = mode_ff;
      byte_in = byte_ff;
      rs_in   = rs_ff;
      idx_in  = idx_ff;
      if (accept) begin
         mode_in = req_data.mode;
         rs_in   = (req_data.mode == lcdnw_pkg::MODE_DATA);
         idx_in  = '0;
         if (req_data.mode == lcdnw_pkg::MODE_POSITION) begin
            byte_in = lcdnw_pkg::CMD_SET_ADDRESS | {1'b0, address};
         end else begin
            byte_in = req_data.value;
         end
      end else if (step_push && !step_full) begin
         idx_in = idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcdnw_pkg::FRONT_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      byte_ff <= byte_in;
      rs_ff   <= rs_in;
   end

endmodule

FILE: src/lcdnw_back.sv
// Back part: turns nibble steps into timed pin states and holds each for its interval.
`timescale 1ns / 1ps

module lcdnw_back (
   input  logic                clock,
   input  logic                reset,
   input  lcdnw_pkg::cfg_type  cfg,
   input  logic                step_empty,
   input  lcdnw_pkg::step_type step_data,
   output logic                step_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output lcdnw_pkg::rsp_type  rsp_data
);

   lcdnw_pkg::back_state_type state_ff, state_in;
   lcdnw_pkg::step_type       step_ff, step_in;
   logic [1:0]                phase_ff, phase_in;
   logic [15:0]               us_left_ff, us_left_in;
   logic [7:0]                pre_ff, pre_in;
   logic                      out_valid_ff, out_valid_in;
   lcdnw_pkg::rsp_type        out_ff, out_in;

   logic               load_out;
   logic               final_phase;
   logic               tick;
   logic               hold_done;
   lcdnw_pkg::rsp_type pin_state;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign hold_done = (us_left_ff == 16'd0);
   assign tick      = ({1'b0, pre_ff} + 9'd1) >= {1'b0, cfg.clocks_per_us};

   always_comb begin
      if (step_ff.kind == lcdnw_pkg::STEP_WAIT) begin
         final_phase = (phase_ff == 2'd0);
      end else begin
         final_phase = (phase_ff == 2'd2);
      end
   end

   always_comb begin
      pin_state                 = '0;
      pin_state.data_nibble     = step_ff.nibble;
      pin_state.register_select = step_ff.rs;
      pin_state.last            = step_ff.last && final_phase;
      if (step_ff.kind == lcdnw_pkg::STEP_WAIT) begin
         pin_state.hold_us = lcdnw_pkg::POWER_UP_US;
      end else begin
         case (phase_ff)
            2'd0: pin_state.hold_us = lcdnw_pkg::STROBE_US;
            2'd1: begin
               pin_state.enable  = 1'b1;
               pin_state.hold_us = lcdnw_pkg::STROBE_US;
            end
            default: pin_state.hold_us = lcdnw_pkg::SETTLE_US + step_ff.extra_us;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcdnw_pkg::BACK_IDLE: begin
            if (!step_empty) begin
               state_in = lcdnw_pkg::BACK_EMIT;
            end
         end
         lcdnw_pkg::BACK_EMIT: begin
            if (!out_valid_ff || rsp_pop) begin
               state_in = lcdnw_pkg::BACK_HOLD;
            end
         end
         lcdnw_pkg::BACK_HOLD: begin
            if (hold_done) begin
               state_in = final_phase ? lcdnw_pkg::BACK_IDLE : lcdnw_pkg::BACK_EMIT;
            end
         end
         default: state_in = lcdnw_pkg::BACK_IDLE;
      endcase
   end

   always_comb begin
      step_pop = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         lcdnw_pkg::BACK_IDLE: step_pop = !step_empty;
         lcdnw_pkg::BACK_EMIT: load_out = !out_valid_ff || rsp_pop;
         default: begin
            step_pop = 1'b0;
            load_out = 1'b0;
         end
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      phase_in     = phase_ff;
      us_left_in   = us_left_ff;
      pre_in       = pre_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (step_pop) begin
         step_in  = step_data;
         phase_in = 2'd0;
      end
      if (load_out) begin
         out_in       = pin_state;
         out_valid_in = 1'b1;
         us_left_in   = pin_state.hold_us;
         pre_in       = 8'd0;
      end else if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (state_ff == lcdnw_pkg::BACK_HOLD) begin
         if (hold_done) begin
            if (!final_phase) begin
               phase_in = phase_ff + 2'd1;
            end
         end else if (tick) begin
            pre_in     = 8'd0;
            us_left_in = us_left_ff - 16'd1;
         end else begin
            pre_in = pre_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcdnw_pkg::BACK_IDLE;
         out_valid_ff <= 1'b0;
         phase_ff     <= '0;
         us_left_ff   <= '0;
         pre_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         us_left_ff   <= us_left_in;
         pre_ff       <= pre_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      out_ff  <= out_in;
   end

endmodule

FILE: src/char_lcd_nibble_writer_top.sv
// Top level of the character LCD nibble writer: configuration registers and part wiring.
//
// A request is pushed on req_push/req_data while req_full is low. Mode command or
// data sends one byte, mode position sends a set-address command built from the
// clamped row and the column, and mode init runs the power-on sequence.
// Each request yields a list of pin states (nibble, RS, E, hold time) on the
// rsp_ queue; the final state of a request has last set. A byte gives six states,
// an initialization gives 37.
// With the back part idle, the first state of a request reaches the rsp_ ports
// via the front state register, step queue, back step register and output register.
// After a state is produced, the next one of the same request appears only when its
// hold time has passed, counted as hold_us microseconds whose length is set by csr
// clocks_per_us through the back part's prescaler. The hold counter in the back part
// and the receiver's pops set the pace of the pin states.
// The front part takes the next request as soon as it has queued the previous one's
// steps, so requests overlap with the pin timing of earlier ones.
// When the receiver does not pop, the back part stalls on its output register and
// the step queue and the front part fill up in turn; nothing is dropped.
// Reset empties the queues and restores the default configuration.
// Configuration is written through csr_write_en, csr_index and csr_wdata.
`timescale 1ns / 1ps

module char_lcd_nibble_writer_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  lcdnw_pkg::req_type req_data,
   output logic               req_full,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output lcdnw_pkg::rsp_type rsp_data,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [7:0]         csr_wdata
);

   lcdnw_pkg::cfg_type  cfg_ff, cfg_in;
   lcdnw_pkg::step_type push_step;
   lcdnw_pkg::step_type pop_step;
   logic                step_push;
   logic                step_full;
   logic                step_pop;
   logic                step_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (lcdnw_pkg::csr_index_type'(csr_index))
            lcdnw_pkg::CSR_NUM_LINES:     cfg_in.num_lines     = csr_wdata[2:0];
            lcdnw_pkg::CSR_TALL_FONT:     cfg_in.tall_font     = csr_wdata[0];
            lcdnw_pkg::CSR_DISPLAY_FLAGS: cfg_in.display_flags = csr_wdata[2:0];
            lcdnw_pkg::CSR_ENTRY_FLAGS:   cfg_in.entry_flags   = csr_wdata[1:0];
            lcdnw_pkg::CSR_CLOCKS_PER_US: cfg_in.clocks_per_us = csr_wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_lines     <= lcdnw_pkg::NUM_LINES_RESET;
         cfg_ff.tall_font     <= lcdnw_pkg::TALL_FONT_RESET;
         cfg_ff.display_flags <= lcdnw_pkg::DISPLAY_FLAGS_RESET;
         cfg_ff.entry_flags   <= lcdnw_pkg::ENTRY_FLAGS_RESET;
         cfg_ff.clocks_per_us <= lcdnw_pkg::CLOCKS_PER_US_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcdnw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .step_push (step_push),
      .step      (push_step),
      .step_full (step_full)
   );

   lcdnw_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (step_push),
      .push_data (push_step),
      .full      (step_full),
      .pop       (step_pop),
      .pop_data  (pop_step),
      .empty     (step_empty)
   );

   lcdnw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .step_empty (step_empty),
      .step_data  (pop_step),
      .step_pop   (step_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: tb/char_lcd_nibble_writer_checker.sv
// Checker for the character LCD nibble writer: predicts each request's pin states and compares them.
`timescale 1ns / 1ps

module char_lcd_nibble_writer_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  lcdnw_pkg::req_type  req_data,
   input  logic                req_full,
   input  logic                rsp_empty,
   input  logic                rsp_pop,
   input  lcdnw_pkg::rsp_type  rsp_data,
   input  logic                csr_write_en,
   input  logic [2:0]          csr_index,
   input  logic [7:0]          csr_wdata,
   output int                  mismatch_count,
   output int                  pending_states,
   output int                  request_count,
   output int                  init_count,
   output int                  states_checked
);

   localparam logic [6:0] LINE_OFFSET [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

   lcdnw_pkg::cfg_type shadow_cfg;
   lcdnw_pkg::rsp_type pin_burst[$];
   lcdnw_pkg::rsp_type expected_pins[$];

   task automatic add_pin(input logic [3:0] nib, input logic rs, input logic en,
                          input logic [15:0] hold);
      lcdnw_pkg::rsp_type pin;
      pin.data_nibble     = nib;
      pin.register_select = rs;
      pin.enable          = en;
      pin.hold_us         = hold;
      pin.last            = 1'b0;
      pin_burst.push_back(pin);
   endtask

   task automatic stretch_last(input logic [15:0] extra);
      lcdnw_pkg::rsp_type pin;
      pin = pin_burst[pin_burst.size() - 1];
      pin.hold_us = pin.hold_us + extra;
      pin_burst[pin_burst.size() - 1] = pin;
   endtask

   task automatic add_strobe(input logic [3:0] nib, input logic rs);
      add_pin(nib, rs, 1'b0, lcdnw_pkg::STROBE_US);
      add_pin(nib, rs, 1'b1, lcdnw_pkg::STROBE_US);
      add_pin(nib, rs, 1'b0, lcdnw_pkg::SETTLE_US);
   endtask

   task automatic add_byte(input logic [7:0] b, input logic rs);
      add_strobe(b[7:4], rs);
      add_strobe(b[3:0], rs);
      if (!rs && b >= 8'd1 && b <= 8'd3) begin
         stretch_last(lcdnw_pkg::LONG_CMD_US);
      end
   endtask

   task automatic predict_pin_states(input lcdnw_pkg::req_type r);
      int                 lines;
      int                 row;
      logic [6:0]         address;
      logic [7:0]         function_set;
      lcdnw_pkg::rsp_type pin;
      pin_burst.delete();
      case (r.mode)
         lcdnw_pkg::MODE_COMMAND: begin
            add_byte(r.value, 1'b0);
         end
         lcdnw_pkg::MODE_DATA: begin
            add_byte(r.value, 1'b1);
         end
         lcdnw_pkg::MODE_POSITION: begin
            lines = (shadow_cfg.num_lines == 3'd0) ? 1 : int'(shadow_cfg.num_lines);
            row = int'(r.row);
            if (row >= lines) begin
               row = lines - 1;
            end
            address = r.column + LINE_OFFSET[row];
            add_byte(lcdnw_pkg::CMD_SET_ADDRESS | {1'b0, address}, 1'b0);
         end
         lcdnw_pkg::MODE_INIT: begin
            function_set = lcdnw_pkg::FS_BASE;
            if (shadow_cfg.num_lines > 3'd1) begin
               function_set = function_set | lcdnw_pkg::FS_TWO_LINE;
            end
            if (shadow_cfg.tall_font && shadow_cfg.num_lines == 3'd1) begin
               function_set = function_set | lcdnw_pkg::FS_TALL_FONT;
            end
            add_pin(4'h0, 1'b0, 1'b0, lcdnw_pkg::POWER_UP_US);
            add_strobe(lcdnw_pkg::WAKE_NIBBLE, 1'b0);
            stretch_last(lcdnw_pkg::WAKE_LONG_US);
            add_strobe(lcdnw_pkg::WAKE_NIBBLE, 1'b0);
            stretch_last(lcdnw_pkg::WAKE_LONG_US);
            add_strobe(lcdnw_pkg::WAKE_NIBBLE, 1'b0);
            stretch_last(lcdnw_pkg::WAKE_SHORT_US);
            add_strobe(lcdnw_pkg::FOUR_BIT_NIBBLE, 1'b0);
            add_byte(function_set, 1'b0);
            add_byte(lcdnw_pkg::DISPLAY_BASE | {5'd0, shadow_cfg.display_flags}, 1'b0);
            add_byte(lcdnw_pkg::CMD_CLEAR, 1'b0);
            add_byte(lcdnw_pkg::ENTRY_BASE | {6'd0, shadow_cfg.entry_flags}, 1'b0);
         end
         default: ;
      endcase
      if (pin_burst.size() > 0) begin
         pin = pin_burst[pin_burst.size() - 1];
         pin.last = 1'b1;
         pin_burst[pin_burst.size() - 1] = pin;
      end
      foreach (pin_burst[i]) begin
         expected_pins.push_back(pin_burst[i]);
      end
   endtask

   function automatic void check_field(input string field, input int unsigned expected,
                                       input int unsigned actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, actual %0d", field, expected, actual);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      lcdnw_pkg::rsp_type oldest;
      if (reset) begin
         expected_pins.delete();
         shadow_cfg.num_lines     = lcdnw_pkg::NUM_LINES_RESET;
         shadow_cfg.tall_font     = lcdnw_pkg::TALL_FONT_RESET;
         shadow_cfg.display_flags = lcdnw_pkg::DISPLAY_FLAGS_RESET;
         shadow_cfg.entry_flags   = lcdnw_pkg::ENTRY_FLAGS_RESET;
         shadow_cfg.clocks_per_us = lcdnw_pkg::CLOCKS_PER_US_RESET;
         mismatch_count = 0;
         request_count  = 0;
         init_count     = 0;
         states_checked = 0;
      end else begin
         if (csr_write_en) begin
            case (lcdnw_pkg::csr_index_type'(csr_index))
               lcdnw_pkg::CSR_NUM_LINES:     shadow_cfg.num_lines     = csr_wdata[2:0];
               lcdnw_pkg::CSR_TALL_FONT:     shadow_cfg.tall_font     = csr_wdata[0];
               lcdnw_pkg::CSR_DISPLAY_FLAGS: shadow_cfg.display_flags = csr_wdata[2:0];
               lcdnw_pkg::CSR_ENTRY_FLAGS:   shadow_cfg.entry_flags   = csr_wdata[1:0];
               lcdnw_pkg::CSR_CLOCKS_PER_US: shadow_cfg.clocks_per_us = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_pins.size() == 0) begin
               $error("Pin state transaction arrived with no expected state waiting.");
               mismatch_count++;
            end else begin
               oldest = expected_pins.pop_front();
               check_field("data_nibble", oldest.data_nibble, rsp_data.data_nibble);
               check_field("register_select", oldest.register_select,
                           rsp_data.register_select);
               check_field("enable", oldest.enable, rsp_data.enable);
               check_field("hold_us", oldest.hold_us, rsp_data.hold_us);
               check_field("last", oldest.last, rsp_data.last);
               states_checked++;
            end
         end
         if (req_push && !req_full) begin
            predict_pin_states(req_data);
            request_count++;
            if (req_data.mode == lcdnw_pkg::MODE_INIT) begin
               init_count++;
            end
         end
      end
      pending_states = expected_pins.size();
   end

endmodule

FILE: tb/char_lcd_nibble_writer_top_tb.sv
// Testbench top for the character LCD nibble writer: stimulus, register settings and verdict.
`timescale 1ns / 1ps

module char_lcd_nibble_writer_top_tb;

   localparam int QUIET_LIMIT      = 200000;
   localparam int HOLDOFF_CYCLES   = 4000;
   localparam int RANDOM_PER_PHASE = 20;
   localparam int PHASES           = 8;

   logic               clock;
   logic               reset;
   logic               req_push;
   lcdnw_pkg::req_type req_data;
   logic               req_full;
   logic               rsp_empty;
   logic               rsp_pop;
   lcdnw_pkg::rsp_type rsp_data;
   logic               csr_write_en;
   logic [2:0]         csr_index;
   logic [7:0]         csr_wdata;

   int mismatch_count;
   int pending_states;
   int request_count;
   int init_count;
   int states_checked;

   int sender_idle_pct;
   int receiver_stall_pct;
   bit holdoff_pending;
   int settings_applied;

   int lines_by_phase   [PHASES] = '{1, 0, 7, 2, 4, 3, 5, 6};
   int tall_by_phase    [PHASES] = '{1, 1, 1, 0, 0, 1, 0, 1};
   int display_by_phase [PHASES] = '{7, 0, 5, 2, 4, 6, 3, 1};
   int entry_by_phase   [PHASES] = '{3, 0, 1, 2, 2, 1, 3, 0};
   int rate_by_phase    [PHASES] = '{1, 1, 1, 1, 1, 2, 1, 1};

   logic [7:0] command_bytes [6] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'hFF};
   logic [7:0] data_bytes    [4] = '{8'h00, 8'h01, 8'h03, 8'hFF};

   char_lcd_nibble_writer_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_data     (req_data),
      .req_full     (req_full),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   char_lcd_nibble_writer_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_data       (req_data),
      .req_full       (req_full),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_states (pending_states),
      .request_count  (request_count),
      .init_count     (init_count),
      .states_checked (states_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic lcdnw_pkg::req_type make_request(input lcdnw_pkg::mode_type mode,
                                                       input logic [7:0] value,
                                                       input logic [6:0] column,
                                                       input logic [1:0] row);
      lcdnw_pkg::req_type r;
      r.mode   = mode;
      r.value  = value;
      r.column = column;
      r.row    = row;
      return r;
   endfunction

   function automatic lcdnw_pkg::req_type random_request();
      lcdnw_pkg::mode_type mode;
      case ($urandom_range(2))
         0:       mode = lcdnw_pkg::MODE_COMMAND;
         1:       mode = lcdnw_pkg::MODE_DATA;
         default: mode = lcdnw_pkg::MODE_POSITION;
      endcase
      return make_request(mode, 8'($urandom), 7'($urandom), 2'($urandom));
   endfunction

   task automatic send_request(input lcdnw_pkg::req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_states != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input lcdnw_pkg::csr_index_type index, input logic [7:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
   endtask

   task automatic apply_setting(input int lines, input int tall, input int display,
                                input int entry, input int rate);
      write_csr(lcdnw_pkg::CSR_NUM_LINES, 8'(lines));
      write_csr(lcdnw_pkg::CSR_TALL_FONT, 8'(tall));
      write_csr(lcdnw_pkg::CSR_DISPLAY_FLAGS, 8'(display));
      write_csr(lcdnw_pkg::CSR_ENTRY_FLAGS, 8'(entry));
      write_csr(lcdnw_pkg::CSR_CLOCKS_PER_US, 8'(rate));
      csr_write_en <= 1'b0;
      settings_applied++;
   endtask

   task automatic set_idling(input int kind);
      case (kind)
         0: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         1: begin
            sender_idle_pct    = 87;
            receiver_stall_pct = 0;
         end
         2: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 87;
         end
         default: begin
            sender_idle_pct    = 34;
            receiver_stall_pct = 34;
         end
      endcase
   endtask

   initial begin : receiver
      int holdoff_left;
      holdoff_left = 0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_pending) begin
            rsp_pop <= 1'b0;
            holdoff_pending = 1'b0;
            holdoff_left = HOLDOFF_CYCLES;
         end else if (holdoff_left > 0) begin
            rsp_pop <= 1'b0;
            holdoff_left--;
         end else begin
            rsp_pop <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int phase;
      req_push           <= 1'b0;
      req_data           <= '0;
      csr_write_en       <= 1'b0;
      csr_index          <= lcdnw_pkg::CSR_NUM_LINES;
      csr_wdata          <= 8'd0;
      reset              <= 1'b1;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      holdoff_pending    = 1'b0;
      settings_applied   = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_request(make_request(lcdnw_pkg::MODE_DATA, 8'hFF, 7'd0, 2'd0));
      send_request(make_request(lcdnw_pkg::MODE_POSITION, 8'h00, 7'd10, 2'd2));
      wait_drained();

      for (phase = 0; phase < PHASES; phase++) begin
         apply_setting(lines_by_phase[phase], tall_by_phase[phase], display_by_phase[phase],
                       entry_by_phase[phase], rate_by_phase[phase]);
         set_idling(phase % 4);
         if (phase == 0) begin
            foreach (command_bytes[i]) begin
               send_request(make_request(lcdnw_pkg::MODE_COMMAND, command_bytes[i],
                                         7'd0, 2'd0));
            end
            foreach (data_bytes[i]) begin
               send_request(make_request(lcdnw_pkg::MODE_DATA, data_bytes[i], 7'd0, 2'd0));
            end
            send_request(make_request(lcdnw_pkg::MODE_POSITION, 8'h00, 7'd0, 2'd0));
         end
         if (phase < 4) begin
            send_request(make_request(lcdnw_pkg::MODE_INIT, 8'h00, 7'd0, 2'd0));
            send_request(make_request(lcdnw_pkg::MODE_POSITION, 8'h00, 7'd127, 2'd3));
         end
         if (phase == 4) begin
            holdoff_pending = 1'b1;
         end
         repeat (RANDOM_PER_PHASE) send_request(random_request());
         wait_drained();
      end

      apply_setting(4, 0, 4, 2, 255);
      set_idling(0);
      send_request(make_request(lcdnw_pkg::MODE_DATA, 8'h5A, 7'd0, 2'd0));
      send_request(make_request(lcdnw_pkg::MODE_POSITION, 8'h00, 7'd5, 2'd3));
      wait_drained();
      repeat (1000) @(posedge clock);

      $display("Run covered %0d requests, %0d of them initializations, over %0d settings.",
               request_count, init_count, settings_applied);
      $display("Compared %0d pin states; %0d field mismatches.", states_checked,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
src/lcdnw_pkg.sv
src/lcdnw_fifo.sv
src/lcdnw_front.sv
src/lcdnw_back.sv
src/char_lcd_nibble_writer_top.sv
tb/char_lcd_nibble_writer_checker.sv
tb/char_lcd_nibble_writer_top_tb.sv
